@@ rtl/core/fisq_pkg.sv @@
`default_nettype none

package fisq_pkg;

    localparam logic [31:0] FP_MAGIC        = 32'h5f3759df;
    localparam logic [31:0] FP_HALF         = 32'h3f000000;
    localparam logic [31:0] FP_THREE_HALVES = 32'h3fc00000;
    localparam logic [31:0] FP_DEFAULT_NAN  = 32'hffc00000;
    localparam logic [31:0] FP_QUIET_BIT    = 32'h00400000;

    // Newton stages per step and the number of quotient bits of the divider.
    localparam int NEWTON_STAGES = 4;
    localparam int NEWTON_STEPS  = 2;
    localparam int FRONT_LAST    = NEWTON_STAGES * NEWTON_STEPS;
    localparam int DIV_BITS      = 26;

    typedef struct packed {
        logic        op;
        logic [31:0] half;
        logic [31:0] y;
        logic [31:0] t;
    } t_front;

    typedef struct packed {
        logic               op;
        logic [31:0]        y;
        logic               spec;
        logic [31:0]        sval;
        logic               sgn;
        logic signed [11:0] eb;
        logic [23:0]        dvs;
        logic [24:0]        rem;
        logic [25:0]        quo;
    } t_div;

    // Leading zeros counted from bit 50.
    function automatic logic [5:0] fp_lzc51(input logic [50:0] v);
        logic [5:0] lz;
        lz = 6'd51;
        for (int i = 0; i < 51; i++) begin
            if (v[i]) begin
                lz = 6'(50 - i);
            end
        end
        return lz;
    endfunction

    // Rounds to nearest even and packs. The leading one of sig sits at bit 49
    // and stands for the biased exponent ex; ex below one gives a subnormal.
    function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] ex,
                                             input logic [49:0] sig, input logic stk);
        logic signed [12:0] rshift;
        logic [5:0]         sh;
        logic [99:0]        ext;
        logic [49:0]        m;
        logic               st;
        logic [7:0]         ef;
        logic               inc;
        logic [30:0]        w;
        rshift = '0;
        sh     = '0;
        ext    = '0;
        if (ex >= 12'sd255) begin
            return {sgn, 8'hff, 23'd0};
        end
        if (ex >= 12'sd1) begin
            m  = sig;
            st = stk;
            ef = ex[7:0];
        end else begin
            rshift = 13'sd1 - $signed({ex[11], ex});
            sh     = (rshift > 13'sd63) ? 6'd63 : rshift[5:0];
            ext    = {sig, 50'd0} >> sh;
            m      = ext[99:50];
            st     = stk | (|ext[49:0]);
            ef     = 8'd0;
        end
        st  = st | (|m[24:0]);
        inc = m[25] & (st | m[26]);
        w   = {ef, m[48:26]} + 31'(inc);
        return {sgn, w};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               sg;
        logic               a_nan, b_nan, a_inf, b_inf, a_zr, b_zr;
        logic [7:0]         ea, eb;
        logic [23:0]        ma, mb;
        logic [47:0]        p;
        logic [5:0]         lz;
        logic signed [11:0] ex;
        sg    = a[31] ^ b[31];
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
        a_zr  = (a[30:0] == 31'd0);
        b_zr  = (b[30:0] == 31'd0);
        ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma    = {a[30:23] != 8'd0, a[22:0]};
        mb    = {b[30:23] != 8'd0, b[22:0]};
        p     = ma * mb;
        lz    = fp_lzc51({p, 3'b000});
        ex    = 12'(ea) + 12'(eb) - 12'd126 - 12'(lz);
        if (a_nan) begin
            return a | FP_QUIET_BIT;
        end
        if (b_nan) begin
            return b | FP_QUIET_BIT;
        end
        if ((a_inf && b_zr) || (b_inf && a_zr)) begin
            return FP_DEFAULT_NAN;
        end
        if (a_inf || b_inf) begin
            return {sg, 8'hff, 23'd0};
        end
        if (a_zr || b_zr) begin
            return {sg, 31'd0};
        end
        return fp_round(sg, ex, {p << lz, 2'b00}, 1'b0);
    endfunction

    // a - b
    function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
        logic               sb, swap, sx, sy;
        logic               a_nan, b_nan, a_inf, b_inf, a_zr, b_zr;
        logic [7:0]         ea, eb, ex, ey, dd;
        logic [23:0]        ma, mb, mx, my;
        logic [5:0]         sh, lz;
        logic [99:0]        ext;
        logic [49:0]        bx, sm;
        logic [50:0]        r, rn;
        logic signed [11:0] e;
        sb    = ~b[31];
        a_nan = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == 8'hff) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
        a_zr  = (a[30:0] == 31'd0);
        b_zr  = (b[30:0] == 31'd0);
        ea    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma    = {a[30:23] != 8'd0, a[22:0]};
        mb    = {b[30:23] != 8'd0, b[22:0]};
        swap  = b[30:0] > a[30:0];
        sx    = swap ? sb : a[31];
        sy    = swap ? a[31] : sb;
        ex    = swap ? eb : ea;
        ey    = swap ? ea : eb;
        mx    = swap ? mb : ma;
        my    = swap ? ma : mb;
        dd    = ex - ey;
        sh    = (dd > 8'd63) ? 6'd63 : dd[5:0];
        bx    = {mx, 26'd0};
        ext   = {my, 26'd0, 50'd0} >> sh;
        sm    = ext[99:50] | {49'd0, |ext[49:0]};
        r     = (sx == sy) ? ({1'b0, bx} + {1'b0, sm}) : ({1'b0, bx} - {1'b0, sm});
        lz    = fp_lzc51(r);
        rn    = r << lz;
        e     = 12'(ex) + 12'd1 - 12'(lz);
        if (a_nan) begin
            return a | FP_QUIET_BIT;
        end
        if (b_nan) begin
            return b | FP_QUIET_BIT;
        end
        if (a_inf && b_inf && (a[31] != sb)) begin
            return FP_DEFAULT_NAN;
        end
        if (a_inf) begin
            return a;
        end
        if (b_inf) begin
            return {sb, b[30:0]};
        end
        if (a_zr && b_zr) begin
            return {a[31] & sb, 31'd0};
        end
        if (b_zr) begin
            return a;
        end
        if (a_zr) begin
            return {sb, b[30:0]};
        end
        if (r == 51'd0) begin
            return 32'd0;
        end
        return fp_round(sx, e, rn[50:1], rn[0]);
    endfunction

    // Prepares 1/y: special operands resolve here, otherwise the divisor is
    // normalized so that its leading one sits at bit 23.
    function automatic t_div fp_div_setup(input logic op, input logic [31:0] y);
        logic [7:0]  ey;
        logic [22:0] fy;
        logic [5:0]  lz;
        t_div        d;
        d     = '0;
        d.op  = op;
        d.y   = y;
        d.sgn = y[31];
        d.rem = 25'h0800000;
        ey    = y[30:23];
        fy    = y[22:0];
        lz    = fp_lzc51({1'b0, fy, 27'd0});
        if (ey == 8'hff) begin
            d.spec = 1'b1;
            d.sval = (fy != 23'd0) ? (y | FP_QUIET_BIT) : {y[31], 31'd0};
        end else if (y[30:0] == 31'd0) begin
            d.spec = 1'b1;
            d.sval = {y[31], 8'hff, 23'd0};
        end else if (ey == 8'd0) begin
            d.dvs = 24'({1'b0, fy} << lz);
            d.eb  = 12'd253 + 12'(lz);
        end else begin
            d.dvs = {1'b1, fy};
            d.eb  = 12'd254 - 12'(ey);
        end
        return d;
    endfunction

    // One restoring division step: one quotient bit.
    function automatic t_div fp_div_step(input t_div d);
        logic        ge;
        logic [24:0] rr;
        t_div        n;
        n     = d;
        ge    = d.rem >= {1'b0, d.dvs};
        rr    = ge ? (d.rem - {1'b0, d.dvs}) : d.rem;
        n.rem = {rr[23:0], 1'b0};
        n.quo = {d.quo[24:0], ge};
        return n;
    endfunction

    function automatic logic [31:0] fp_div_final(input t_div d);
        if (!d.op) begin
            return d.y;
        end
        if (d.spec) begin
            return d.sval;
        end
        if (d.quo[25]) begin
            return fp_round(d.sgn, d.eb, {d.quo, 24'd0}, |d.rem);
        end
        return fp_round(d.sgn, d.eb - 12'sd1, {d.quo[24:0], 25'd0}, |d.rem);
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/fast_inverse_sqrt_unit.sv @@
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------
// input    | start / busy       | i_operation, i_x_bits
// output   | o_valid (strobe)   | o_result_bits
//
// One beat is accepted every cycle; busy never rises.
// A result passes from its input beat through one stage for the seed and the
// half, four stages per Newton step, one divider setup stage, 26 divider
// stages at one quotient bit each, and the output register.
// Reset is synchronous and clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module fast_inverse_sqrt_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [31:0] i_x_bits,
    output logic        o_valid,
    output logic [31:0] o_result_bits
);
    import fisq_pkg::*;

    // Front section: seed and the two Newton steps. Each step runs as
    // half*y, then times y, then 1.5 minus that, then y times the difference.
    logic                 r_fv [0:FRONT_LAST];
    t_front               r_fp [0:FRONT_LAST];
    // Divider section: setup, then one quotient bit per stage.
    logic                 r_dvv [0:DIV_BITS];
    t_div                 r_dv  [0:DIV_BITS];
    logic                 r_out_vld;
    logic [31:0]          r_out_bits;

    assign busy          = 1'b0;
    assign o_valid       = r_out_vld;
    assign o_result_bits = r_out_bits;

    // Valid bits travel beside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= FRONT_LAST; k++) begin
                r_fv[k] <= 1'b0;
            end
            for (int k = 0; k <= DIV_BITS; k++) begin
                r_dvv[k] <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else begin
            r_fv[0] <= start && !busy;
            for (int k = 1; k <= FRONT_LAST; k++) begin
                r_fv[k] <= r_fv[k-1];
            end
            r_dvv[0] <= r_fv[FRONT_LAST];
            for (int k = 1; k <= DIV_BITS; k++) begin
                r_dvv[k] <= r_dvv[k-1];
            end
            r_out_vld <= r_dvv[DIV_BITS];
        end
    end

    // The seed subtracts the arithmetically shifted input bits from the
    // magic constant, wrapping in 32 bits.
    always_ff @(posedge i_clk) begin
        r_fp[0] <= '{op:   i_operation,
                     half: fp_mul(i_x_bits, FP_HALF),
                     y:    FP_MAGIC - {i_x_bits[31], i_x_bits[31:1]},
                     t:    32'd0};
    end

    for (genvar k = 1; k <= FRONT_LAST; k++) begin : g_newton
        if ((k - 1) % NEWTON_STAGES == 0) begin : g_hy
            always_ff @(posedge i_clk) begin
                r_fp[k] <= '{op: r_fp[k-1].op, half: r_fp[k-1].half, y: r_fp[k-1].y,
                             t: fp_mul(r_fp[k-1].half, r_fp[k-1].y)};
            end
        end else if ((k - 1) % NEWTON_STAGES == 1) begin : g_hyy
            always_ff @(posedge i_clk) begin
                r_fp[k] <= '{op: r_fp[k-1].op, half: r_fp[k-1].half, y: r_fp[k-1].y,
                             t: fp_mul(r_fp[k-1].t, r_fp[k-1].y)};
            end
        end else if ((k - 1) % NEWTON_STAGES == 2) begin : g_sub
            always_ff @(posedge i_clk) begin
                r_fp[k] <= '{op: r_fp[k-1].op, half: r_fp[k-1].half, y: r_fp[k-1].y,
                             t: fp_sub(FP_THREE_HALVES, r_fp[k-1].t)};
            end
        end else begin : g_upd
            always_ff @(posedge i_clk) begin
                r_fp[k] <= '{op: r_fp[k-1].op, half: r_fp[k-1].half,
                             y: fp_mul(r_fp[k-1].y, r_fp[k-1].t), t: r_fp[k-1].t};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv[0] <= fp_div_setup(r_fp[FRONT_LAST].op, r_fp[FRONT_LAST].y);
    end

    for (genvar k = 1; k <= DIV_BITS; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            r_dv[k] <= fp_div_step(r_dv[k-1]);
        end
    end

    // Rounding and the choice between y and 1/y.
    always_ff @(posedge i_clk) begin
        r_out_bits <= fp_div_final(r_dv[DIV_BITS]);
    end

    // A result strobe always goes back to an accepted input beat.
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $past(start && !busy, 37))
        else $error("result strobe without a matching input beat");

    // The reciprocal square root leaves the divider untouched.
    a_rsqrt_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dvv[DIV_BITS] && !r_dv[DIV_BITS].op) |=> (r_out_bits == $past(r_dv[DIV_BITS].y)))
        else $error("reciprocal square root altered on its way out");

    // A regular divisor enters the divider normalized.
    a_div_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dvv[0] && !r_dv[0].spec) |-> r_dv[0].dvs[23])
        else $error("divisor not normalized");

endmodule

`default_nettype wire
